[sv/ofp_pkg.sv]
// Shared types and constants for the face-line parser.
package ofp_pkg;

   localparam int INDEX_WIDTH = 20;
   localparam int COUNT_WIDTH = 21;
   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;

   localparam logic [0:0] REG_VERTEX_COUNT = 1'b0;

   localparam logic [7:0] CHAR_F     = 8'h66;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_NL    = 8'h0A;
   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   typedef enum logic [2:0] {
      PH_LINE_START = 3'd0,
      PH_SAW_F      = 3'd1,
      PH_IGNORE     = 3'd2,
      PH_SKIP_WS    = 3'd3,
      PH_SIGN       = 3'd4,
      PH_DIGITS     = 3'd5,
      PH_SKIP_TOKEN = 3'd6,
      PH_DONE       = 3'd7
   } phase_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NO_DIGITS = 2'd1,
      ST_RANGE     = 2'd2,
      ST_SHORT     = 2'd3
   } status_type;

   typedef struct packed {
      phase_type  phase;
      logic [1:0] tokens;
      logic       negative;
      status_type err;
   } parse_ctrl_type;

   typedef struct packed {
      status_type              status;
      logic [INDEX_WIDTH-1:0]  first_index;
      logic [INDEX_WIDTH-1:0]  second_index;
      logic [INDEX_WIDTH-1:0]  third_index;
   } face_result_type;

endpackage

[sv/ofp_csr.sv]
// Configuration register block: vertex count over an APB-style port.
module ofp_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [ofp_pkg::CSR_ADDR_WIDTH-1:0]    csr_paddr,
   input  logic [ofp_pkg::CSR_DATA_WIDTH-1:0]    csr_pwdata,
   output logic [ofp_pkg::CSR_DATA_WIDTH-1:0]    csr_prdata,
   output logic                                  csr_pready,
   output logic [ofp_pkg::COUNT_WIDTH-1:0]       vertex_count
);

   logic [ofp_pkg::COUNT_WIDTH-1:0] vertex_count_ff;
   logic [ofp_pkg::COUNT_WIDTH-1:0] vertex_count_in;
   logic                            hit;

   assign csr_pready = 1'b1;
   assign hit = (csr_paddr[ofp_pkg::CSR_ADDR_WIDTH-1] == ofp_pkg::REG_VERTEX_COUNT);

   always_comb begin
      vertex_count_in = vertex_count_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready && hit) begin
         vertex_count_in = csr_pwdata[ofp_pkg::COUNT_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_count_ff <= '0;
      end else begin
         vertex_count_ff <= vertex_count_in;
      end
   end

   assign csr_prdata = hit ? ofp_pkg::CSR_DATA_WIDTH'(vertex_count_ff) : '0;
   assign vertex_count = vertex_count_ff;

endmodule

[sv/ofp_step.sv]
// Per-byte parse step: next parser state and the face result at line end.
module ofp_step #(
   parameter int MAX_VERTICES = 1048576,
   parameter int ACC_WIDTH = $clog2(MAX_VERTICES + 2)
) (
   input  ofp_pkg::parse_ctrl_type               ctrl_cur,
   input  logic [ACC_WIDTH-1:0]                  acc_cur,
   input  logic [ofp_pkg::INDEX_WIDTH-1:0]       held0_cur,
   input  logic [ofp_pkg::INDEX_WIDTH-1:0]       held1_cur,
   input  logic [7:0]                            text_byte,
   input  logic                                  final_byte,
   input  logic [ofp_pkg::COUNT_WIDTH-1:0]       vertex_count,
   output ofp_pkg::parse_ctrl_type               ctrl_nxt,
   output logic [ACC_WIDTH-1:0]                  acc_nxt,
   output logic [ofp_pkg::INDEX_WIDTH-1:0]       held0_nxt,
   output logic [ofp_pkg::INDEX_WIDTH-1:0]       held1_nxt,
   output logic                                  emit,
   output ofp_pkg::face_result_type              result
);

   localparam int XW = (ACC_WIDTH > ofp_pkg::COUNT_WIDTH) ? ACC_WIDTH : ofp_pkg::COUNT_WIDTH;
   localparam int VW = ACC_WIDTH + 4;
   localparam logic [VW-1:0] CAP = VW'(MAX_VERTICES + 1);
   localparam logic [XW-1:0] MAX_X = XW'(MAX_VERTICES);

   logic [XW-1:0] limit;
   logic [XW-1:0] vc_x;
   logic [VW-1:0] acc_times_ten;
   logic [VW-1:0] acc_sat;
   logic [VW-1:0] digit_sat;
   logic [3:0]    digit;
   logic          is_digit;
   logic          is_newline;
   logic          line_end;
   logic          do_finish;
   logic          face_line;
   logic          range_bad;
   logic [XW-1:0] acc_x;
   logic [XW-1:0] acc_m1;

   assign vc_x = XW'(vertex_count);
   assign limit = (vc_x < MAX_X) ? vc_x : MAX_X;
   assign is_digit = (text_byte >= ofp_pkg::CHAR_ZERO) && (text_byte <= ofp_pkg::CHAR_NINE);
   assign digit = 4'(text_byte - ofp_pkg::CHAR_ZERO);
   assign is_newline = (text_byte == ofp_pkg::CHAR_NL);
   assign line_end = is_newline || final_byte;

   // accumulate a digit with saturation at one past the vertex ceiling
   always_comb begin
      acc_times_ten = (VW'(acc_cur) << 3) + (VW'(acc_cur) << 1) + VW'(digit);
      acc_sat = (acc_times_ten > CAP) ? CAP : acc_times_ten;
      digit_sat = (VW'(digit) > CAP) ? CAP : VW'(digit);
   end

   always_comb begin
      ctrl_nxt = ctrl_cur;
      acc_nxt = acc_cur;
      held0_nxt = held0_cur;
      held1_nxt = held1_cur;
      do_finish = 1'b0;
      emit = 1'b0;
      result = '0;

      if (!is_newline) begin
         unique case (ctrl_cur.phase)
            ofp_pkg::PH_LINE_START: begin
               ctrl_nxt.phase = (text_byte == ofp_pkg::CHAR_F) ?
                                ofp_pkg::PH_SAW_F : ofp_pkg::PH_IGNORE;
            end
            ofp_pkg::PH_SAW_F: begin
               if (text_byte == ofp_pkg::CHAR_SPACE) begin
                  ctrl_nxt.phase = ofp_pkg::PH_SKIP_WS;
                  ctrl_nxt.tokens = 2'd0;
                  ctrl_nxt.negative = 1'b0;
                  ctrl_nxt.err = ofp_pkg::ST_OK;
                  acc_nxt = '0;
               end else begin
                  ctrl_nxt.phase = ofp_pkg::PH_IGNORE;
               end
            end
            ofp_pkg::PH_SKIP_WS: begin
               if (text_byte == ofp_pkg::CHAR_SPACE || text_byte == ofp_pkg::CHAR_TAB) begin
                  ctrl_nxt.phase = ofp_pkg::PH_SKIP_WS;
               end else if (text_byte == ofp_pkg::CHAR_NUL) begin
                  ctrl_nxt.phase = ofp_pkg::PH_DONE;
               end else if (text_byte == ofp_pkg::CHAR_PLUS ||
                            text_byte == ofp_pkg::CHAR_MINUS) begin
                  ctrl_nxt.negative = (text_byte == ofp_pkg::CHAR_MINUS);
                  acc_nxt = '0;
                  ctrl_nxt.phase = ofp_pkg::PH_SIGN;
               end else if (is_digit) begin
                  ctrl_nxt.negative = 1'b0;
                  acc_nxt = digit_sat[ACC_WIDTH-1:0];
                  ctrl_nxt.phase = ofp_pkg::PH_DIGITS;
               end else begin
                  ctrl_nxt.err = ofp_pkg::ST_NO_DIGITS;
                  ctrl_nxt.phase = ofp_pkg::PH_DONE;
               end
            end
            ofp_pkg::PH_SIGN: begin
               if (is_digit) begin
                  acc_nxt = acc_sat[ACC_WIDTH-1:0];
                  ctrl_nxt.phase = ofp_pkg::PH_DIGITS;
               end else begin
                  ctrl_nxt.err = ofp_pkg::ST_NO_DIGITS;
                  ctrl_nxt.phase = ofp_pkg::PH_DONE;
               end
            end
            ofp_pkg::PH_DIGITS: begin
               if (is_digit) begin
                  acc_nxt = acc_sat[ACC_WIDTH-1:0];
               end else begin
                  do_finish = 1'b1;
               end
            end
            ofp_pkg::PH_SKIP_TOKEN: begin
               if (text_byte == ofp_pkg::CHAR_SPACE) begin
                  ctrl_nxt.phase = ofp_pkg::PH_SKIP_WS;
               end else if (text_byte == ofp_pkg::CHAR_NUL) begin
                  ctrl_nxt.phase = ofp_pkg::PH_DONE;
               end
            end
            default: begin
               ctrl_nxt.phase = ctrl_cur.phase;
            end
         endcase
      end

      face_line = (ctrl_nxt.phase == ofp_pkg::PH_SKIP_WS)  ||
                  (ctrl_nxt.phase == ofp_pkg::PH_SIGN)     ||
                  (ctrl_nxt.phase == ofp_pkg::PH_DIGITS)   ||
                  (ctrl_nxt.phase == ofp_pkg::PH_SKIP_TOKEN) ||
                  (ctrl_nxt.phase == ofp_pkg::PH_DONE);

      if (line_end && ctrl_nxt.phase == ofp_pkg::PH_DIGITS) begin
         do_finish = 1'b1;
      end

      // close the token held in the accumulator
      acc_x = XW'(acc_nxt);
      acc_m1 = acc_x - XW'(1);
      range_bad = ctrl_nxt.negative || (acc_x == '0) || (acc_x > limit);
      if (do_finish) begin
         if (range_bad) begin
            ctrl_nxt.err = ofp_pkg::ST_RANGE;
            ctrl_nxt.phase = ofp_pkg::PH_DONE;
         end else begin
            if (ctrl_nxt.tokens == 2'd0) begin
               held0_nxt = acc_m1[ofp_pkg::INDEX_WIDTH-1:0];
            end
            if (ctrl_nxt.tokens == 2'd1) begin
               held1_nxt = acc_m1[ofp_pkg::INDEX_WIDTH-1:0];
            end
            ctrl_nxt.tokens = ctrl_nxt.tokens + 2'd1;
            if (ctrl_nxt.tokens == 2'd3) begin
               ctrl_nxt.phase = ofp_pkg::PH_DONE;
            end else if (text_byte == ofp_pkg::CHAR_SPACE) begin
               ctrl_nxt.phase = ofp_pkg::PH_SKIP_WS;
            end else if (text_byte == ofp_pkg::CHAR_NUL) begin
               ctrl_nxt.phase = ofp_pkg::PH_DONE;
            end else begin
               ctrl_nxt.phase = ofp_pkg::PH_SKIP_TOKEN;
            end
         end
      end

      if (line_end) begin
         if (ctrl_nxt.phase == ofp_pkg::PH_SIGN) begin
            ctrl_nxt.err = ofp_pkg::ST_NO_DIGITS;
         end
         ctrl_nxt.phase = ofp_pkg::PH_LINE_START;
         emit = face_line;
         if (ctrl_nxt.err != ofp_pkg::ST_OK) begin
            result.status = ctrl_nxt.err;
         end else if (ctrl_nxt.tokens != 2'd3) begin
            result.status = ofp_pkg::ST_SHORT;
         end else begin
            result.status = ofp_pkg::ST_OK;
            result.first_index = held0_nxt;
            result.second_index = held1_nxt;
            result.third_index = acc_m1[ofp_pkg::INDEX_WIDTH-1:0];
         end
      end
   end

endmodule

[sv/obj_face_line_parser.sv]
// Top level of the face-line parser: input stage, parser state and result register.
//
//  channel  | direction | payload
//  req_*    | in        | tdata[7:0] text_byte, tlast final_byte
//  rsp_*    | out       | tuser[1:0] status, tdata[19:0]/[39:20]/[59:40] indices
//  csr_*    | in/out    | vertex_count at byte address 0
//
// One byte per cycle sustained while no waiting result stalls; a byte is parsed
// from the input stage and its result, if any, is shown in the cycle after that.
// Reset clears the parser to line start and vertex_count to zero.
// A waiting result stalls only a byte that closes a face line; other bytes
// keep flowing past it.
module obj_face_line_parser #(
   parameter int MAX_VERTICES = 1048576
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [7:0]                            req_tdata,  // [7:0] text_byte
   input  logic                                  req_tlast,  // final_byte
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [63:0]                           rsp_tdata,  // first, second, third index
   output logic [1:0]                            rsp_tuser,  // status
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [ofp_pkg::CSR_ADDR_WIDTH-1:0]    csr_paddr,
   input  logic [ofp_pkg::CSR_DATA_WIDTH-1:0]    csr_pwdata,
   output logic [ofp_pkg::CSR_DATA_WIDTH-1:0]    csr_prdata,
   output logic                                  csr_pready
);

   localparam int ACC_WIDTH = $clog2(MAX_VERTICES + 2);

   logic [ofp_pkg::COUNT_WIDTH-1:0] vertex_count;

   logic                            in_valid_ff, in_valid_in;
   logic [7:0]                      in_byte_ff;
   logic                            in_last_ff;

   ofp_pkg::parse_ctrl_type         ctrl_ff, ctrl_in;
   logic [ACC_WIDTH-1:0]            acc_ff, acc_in;
   logic [ofp_pkg::INDEX_WIDTH-1:0] held0_ff, held0_in;
   logic [ofp_pkg::INDEX_WIDTH-1:0] held1_ff, held1_in;

   logic                            out_valid_ff, out_valid_in;
   ofp_pkg::face_result_type        out_ff;

   ofp_pkg::parse_ctrl_type         ctrl_nxt;
   logic [ACC_WIDTH-1:0]            acc_nxt;
   logic [ofp_pkg::INDEX_WIDTH-1:0] held0_nxt, held1_nxt;
   logic                            emit;
   ofp_pkg::face_result_type        result;
   logic                            fire;
   logic                            req_take;

   ofp_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_prdata   (csr_prdata),
      .csr_pready   (csr_pready),
      .vertex_count (vertex_count)
   );

   ofp_step #(
      .MAX_VERTICES (MAX_VERTICES),
      .ACC_WIDTH    (ACC_WIDTH)
   ) u_step (
      .ctrl_cur     (ctrl_ff),
      .acc_cur      (acc_ff),
      .held0_cur    (held0_ff),
      .held1_cur    (held1_ff),
      .text_byte    (in_byte_ff),
      .final_byte   (in_last_ff),
      .vertex_count (vertex_count),
      .ctrl_nxt     (ctrl_nxt),
      .acc_nxt      (acc_nxt),
      .held0_nxt    (held0_nxt),
      .held1_nxt    (held1_nxt),
      .emit         (emit),
      .result       (result)
   );

   assign fire = in_valid_ff && (!emit || !out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || fire;
   assign req_take = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end

      ctrl_in = ctrl_ff;
      acc_in = acc_ff;
      held0_in = held0_ff;
      held1_in = held1_ff;
      if (fire) begin
         ctrl_in = ctrl_nxt;
         acc_in = acc_nxt;
         held0_in = held0_nxt;
         held1_in = held1_nxt;
      end

      out_valid_in = out_valid_ff;
      if (fire && emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         ctrl_ff      <= '{phase: ofp_pkg::PH_LINE_START, tokens: 2'd0,
                           negative: 1'b0, err: ofp_pkg::ST_OK};
         acc_ff       <= '0;
         held0_ff     <= '0;
         held1_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         ctrl_ff      <= ctrl_in;
         acc_ff       <= acc_in;
         held0_ff     <= held0_in;
         held1_ff     <= held1_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (fire && emit) begin
         out_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ff.status;
   assign rsp_tdata  = {4'b0000, out_ff.third_index, out_ff.second_index, out_ff.first_index};

endmodule
